[rtl/sporadic_server_budget_assert.svh]
// Assertion macros shared by the sporadic-server budget RTL.
`ifndef SPORADIC_SERVER_BUDGET_ASSERT_SVH
`define SPORADIC_SERVER_BUDGET_ASSERT_SVH
`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define SSB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sporadic_server_budget: assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define SSB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sporadic_server_budget: assertion failed");
`else
`define SSB_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SSB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/ssb_pkg.sv]
// Shared types and constants of the sporadic-server budget engine.
`default_nettype none
package ssb_pkg;

  localparam int RING_DEPTH_DEF = 8;

  localparam int CMD_W    = 3;
  localparam int TIME_W   = 48;
  localparam int BUDGET_W = 16;
  localparam int PERIOD_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_REINIT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ACTIVATE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_COMPLETE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CONSUME  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PROCESS  = 3'd4;

  localparam logic [1:0] ST_IDLE      = 2'd0;
  localparam logic [1:0] ST_ACTIVE    = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FULL_BUDGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRANULARITY = 2'd2;

  localparam logic [BUDGET_W-1:0] FULL_BUDGET_RST = 16'd100;
  localparam logic [PERIOD_W-1:0] PERIOD_RST      = 32'd1000;
  localparam logic [BUDGET_W-1:0] GRANULARITY_RST = 16'd1;

  typedef struct packed {
    logic [BUDGET_W-1:0] full_budget;
    logic [PERIOD_W-1:0] replenish_period;
    logic [BUDGET_W-1:0] tick_granularity;
  } ssb_cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]   when;
    logic [BUDGET_W-1:0] amount;
  } ssb_entry_t;

  typedef struct packed {
    logic                may_run;
    logic [1:0]          server_state;
    logic [BUDGET_W-1:0] budget_left;
    logic [3:0]          pending_count;
    logic [BUDGET_W-1:0] merged_count;
    logic                exhausted_event;
    logic                resumed_event;
  } ssb_result_t;

endpackage
`default_nettype wire

[rtl/sporadic_server_budget.sv]
// Sporadic-server budget engine top level: configuration, sequencer, ring and output beat.
// The block handles one command at a time and returns one result beat per command.
// From the accepting edge, the sequencer passes through EXEC and then DONE for
// reinit, activate, a complete or consume that queues nothing, and unknown codes;
// queueing into a free ring slot adds QUEUE between them, and merging into the newest
// entry of a full ring adds QUEUE and MERGE (one read and one write of the ring memory).
// Processing stays in PCHK while ring entries are examined, at most RING_DEPTH of them,
// because the ring memory gives one entry per cycle. A new command is accepted in the
// cycle after the result moves into the output register. The ring memory has no reset;
// only entries that were written are read.
`default_nettype none
module sporadic_server_budget #(
  parameter int RING_DEPTH = ssb_pkg::RING_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [ssb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ssb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [ssb_pkg::CMD_W-1:0]        in_command,
  input  wire logic [ssb_pkg::TIME_W-1:0]       in_current_time,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_may_run,
  output logic [1:0]                            out_server_state,
  output logic [ssb_pkg::BUDGET_W-1:0]          out_budget_left,
  output logic [3:0]                            out_pending_count,
  output logic [ssb_pkg::BUDGET_W-1:0]          out_merged_count,
  output logic                                  out_exhausted_event,
  output logic                                  out_resumed_event
);
  import ssb_pkg::*;
  `include "sporadic_server_budget_assert.svh"

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FW = $clog2(RING_DEPTH + 1);

  ssb_cfg_t    cfg_r;
  ssb_result_t core_res;
  ssb_result_t out_res_r;
  logic        out_valid_r;
  logic        core_valid;
  logic        core_take;
  logic        mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  ssb_entry_t  mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.full_budget      <= FULL_BUDGET_RST;
      cfg_r.replenish_period <= PERIOD_RST;
      cfg_r.tick_granularity <= GRANULARITY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FULL_BUDGET: cfg_r.full_budget      <= cfg_wdata[BUDGET_W-1:0];
        CFG_PERIOD:      cfg_r.replenish_period <= cfg_wdata[PERIOD_W-1:0];
        CFG_GRANULARITY: cfg_r.tick_granularity <= cfg_wdata[BUDGET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ssb_core #(
    .RING_DEPTH (RING_DEPTH),
    .AW         (AW),
    .FW         (FW)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_current_time (in_current_time),
    .res_valid       (core_valid),
    .res_take        (core_take),
    .res             (core_res),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_re          (mem_re),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata)
  );

  ssb_ring_mem #(
    .RING_DEPTH (RING_DEPTH),
    .AW         (AW)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The output register frees the sequencer while a result beat waits downstream.
  assign core_take = core_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (core_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_take) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_may_run         = out_res_r.may_run;
  assign out_server_state    = out_res_r.server_state;
  assign out_budget_left     = out_res_r.budget_left;
  assign out_pending_count   = out_res_r.pending_count;
  assign out_merged_count    = out_res_r.merged_count;
  assign out_exhausted_event = out_res_r.exhausted_event;
  assign out_resumed_event   = out_res_r.resumed_event;

  `SSB_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)
  `SSB_ASSERT_NOW(a_exhaust_beat, clk, rst_n, out_valid && out_exhausted_event,
                  out_server_state == ST_EXHAUSTED && out_budget_left == '0 && !out_may_run)
  `SSB_ASSERT_NOW(a_resume_beat, clk, rst_n, out_valid && out_resumed_event,
                  out_server_state == ST_ACTIVE && out_budget_left != '0)

endmodule
`default_nettype wire

[rtl/ssb_ring_mem.sv]
// Replenishment ring storage: one write port and one registered read port.
`default_nettype none
module ssb_ring_mem #(
  parameter int RING_DEPTH = ssb_pkg::RING_DEPTH_DEF,
  parameter int AW = 3
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [AW-1:0]      waddr,
  input  wire ssb_pkg::ssb_entry_t wdata,
  input  wire logic               re,
  input  wire logic [AW-1:0]      raddr,
  output ssb_pkg::ssb_entry_t      rdata
);
  import ssb_pkg::*;

  ssb_entry_t mem [RING_DEPTH];
  ssb_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[rtl/ssb_core.sv]
// Command sequencer: server state registers and read-modify-write of the ring.
`default_nettype none
module ssb_core #(
  parameter int RING_DEPTH = ssb_pkg::RING_DEPTH_DEF,
  parameter int AW = 3,
  parameter int FW = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire ssb_pkg::ssb_cfg_t             cfg,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [ssb_pkg::CMD_W-1:0]    in_command,
  input  wire logic [ssb_pkg::TIME_W-1:0]   in_current_time,
  output logic                              res_valid,
  input  wire logic                         res_take,
  output ssb_pkg::ssb_result_t               res,
  output logic                              mem_we,
  output logic [AW-1:0]                     mem_waddr,
  output ssb_pkg::ssb_entry_t                mem_wdata,
  output logic                              mem_re,
  output logic [AW-1:0]                     mem_raddr,
  input  wire ssb_pkg::ssb_entry_t           mem_rdata
);
  import ssb_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_QUEUE = 3'd2;
  localparam logic [2:0] S_MERGE = 3'd3;
  localparam logic [2:0] S_PCHK  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [AW-1:0] LAST_IDX  = AW'(RING_DEPTH - 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(RING_DEPTH);

  logic [2:0]          fsm_r, fsm_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [1:0]          run_r, run_nxt;
  logic [BUDGET_W-1:0] budget_r, budget_nxt;
  logic [BUDGET_W-1:0] used_r, used_nxt;
  logic [TIME_W-1:0]   stamp_r, stamp_nxt;
  logic [BUDGET_W-1:0] phase_r, phase_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [AW-1:0]       tail_r, tail_nxt;
  logic [FW-1:0]       fill_r, fill_nxt;
  logic [BUDGET_W-1:0] merge_r, merge_nxt;
  logic [BUDGET_W-1:0] amt_r, amt_nxt;
  logic [TIME_W-1:0]   rtime_r, rtime_nxt;
  logic                may_r, may_nxt;
  logic                exh_r, exh_nxt;
  logic                resv_r, resv_nxt;

  logic [AW-1:0]       head_inc, tail_inc, newest;
  logic [TIME_W:0]     refill_sum;
  logic [TIME_W-1:0]   refill_time;
  logic                phase_wrap;
  logic [BUDGET_W-1:0] used_inc;
  logic [BUDGET_W:0]   merge_sum, restore_sum;
  logic [BUDGET_W-1:0] merge_amt, restore_amt;

  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
  assign newest   = (tail_r == '0) ? LAST_IDX : tail_r - 1'b1;

  // Replenishment time saturates at the largest 48-bit time.
  assign refill_sum  = {1'b0, stamp_r} + {{(TIME_W + 1 - PERIOD_W){1'b0}}, cfg.replenish_period};
  assign refill_time = refill_sum[TIME_W] ? '1 : refill_sum[TIME_W-1:0];

  assign phase_wrap = ({1'b0, phase_r} + 17'd1) >= {1'b0, cfg.tick_granularity};
  assign used_inc   = (used_r == '1) ? used_r : used_r + 1'b1;

  assign merge_sum   = {1'b0, mem_rdata.amount} + {1'b0, amt_r};
  assign merge_amt   = (merge_sum > {1'b0, cfg.full_budget}) ? cfg.full_budget
                                                             : merge_sum[BUDGET_W-1:0];
  assign restore_sum = {1'b0, budget_r} + {1'b0, mem_rdata.amount};
  assign restore_amt = (restore_sum > {1'b0, cfg.full_budget}) ? cfg.full_budget
                                                               : restore_sum[BUDGET_W-1:0];

  always_comb begin
    fsm_nxt    = fsm_r;
    cmd_nxt    = cmd_r;
    now_nxt    = now_r;
    run_nxt    = run_r;
    budget_nxt = budget_r;
    used_nxt   = used_r;
    stamp_nxt  = stamp_r;
    phase_nxt  = phase_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    fill_nxt   = fill_r;
    merge_nxt  = merge_r;
    amt_nxt    = amt_r;
    rtime_nxt  = rtime_r;
    may_nxt    = may_r;
    exh_nxt    = exh_r;
    resv_nxt   = resv_r;
    mem_we     = 1'b0;
    mem_waddr  = tail_r;
    mem_wdata  = '{when: refill_time, amount: amt_r};
    mem_re     = 1'b0;
    mem_raddr  = head_r;

    case (fsm_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_command;
          now_nxt = in_current_time;
          fsm_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        may_nxt  = 1'b0;
        exh_nxt  = 1'b0;
        resv_nxt = 1'b0;
        fsm_nxt  = S_DONE;
        case (cmd_r)
          CMD_REINIT: begin
            run_nxt    = ST_IDLE;
            budget_nxt = cfg.full_budget;
            used_nxt   = '0;
            stamp_nxt  = '0;
            phase_nxt  = '0;
            head_nxt   = '0;
            tail_nxt   = '0;
            fill_nxt   = '0;
            merge_nxt  = '0;
          end
          CMD_ACTIVATE: begin
            if (run_r == ST_IDLE) begin
              run_nxt   = ST_ACTIVE;
              stamp_nxt = now_r;
              used_nxt  = '0;
            end
          end
          CMD_COMPLETE: begin
            if (run_r == ST_ACTIVE) begin
              amt_nxt  = used_r;
              run_nxt  = ST_IDLE;
              used_nxt = '0;
              if (used_r != '0) begin
                fsm_nxt = S_QUEUE;
              end
            end
          end
          CMD_CONSUME: begin
            if (run_r != ST_IDLE) begin
              if (budget_r == '0) begin
                run_nxt = ST_EXHAUSTED;
              end else begin
                may_nxt = 1'b1;
                if (cfg.tick_granularity > 16'd1 && !phase_wrap) begin
                  phase_nxt = phase_r + 1'b1;
                end else begin
                  if (cfg.tick_granularity > 16'd1) begin
                    phase_nxt = '0;
                  end
                  budget_nxt = budget_r - 1'b1;
                  used_nxt   = used_inc;
                  // Spending the last unit queues the whole usage for refill.
                  if (budget_r == 16'd1) begin
                    amt_nxt = used_inc;
                    run_nxt = ST_EXHAUSTED;
                    exh_nxt = 1'b1;
                    may_nxt = 1'b0;
                    fsm_nxt = S_QUEUE;
                  end
                end
              end
            end
          end
          CMD_PROCESS: begin
            if (fill_r != '0) begin
              mem_re    = 1'b1;
              mem_raddr = head_r;
              fsm_nxt   = S_PCHK;
            end
          end
          default: begin
            fsm_nxt = S_DONE;
          end
        endcase
      end
      S_QUEUE: begin
        rtime_nxt = refill_time;
        if (fill_r != FILL_FULL) begin
          mem_we    = 1'b1;
          mem_waddr = tail_r;
          tail_nxt  = tail_inc;
          fill_nxt  = fill_r + 1'b1;
          fsm_nxt   = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = newest;
          fsm_nxt   = S_MERGE;
        end
      end
      S_MERGE: begin
        // The newest entry was read last cycle and nothing else touches the ring.
        mem_we    = 1'b1;
        mem_waddr = newest;
        mem_wdata = '{when: (rtime_r > mem_rdata.when) ? rtime_r : mem_rdata.when,
                      amount: merge_amt};
        if (merge_r != '1) begin
          merge_nxt = merge_r + 1'b1;
        end
        fsm_nxt = S_DONE;
      end
      S_PCHK: begin
        if (mem_rdata.when > now_r) begin
          fsm_nxt = S_DONE;
        end else begin
          head_nxt   = head_inc;
          fill_nxt   = fill_r - 1'b1;
          budget_nxt = restore_amt;
          if (restore_amt != '0 && run_r == ST_EXHAUSTED) begin
            run_nxt  = ST_ACTIVE;
            resv_nxt = 1'b1;
          end
          if (fill_r != FW'(1)) begin
            mem_re    = 1'b1;
            mem_raddr = head_inc;
          end else begin
            fsm_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (res_take) begin
          fsm_nxt = S_IDLE;
        end
      end
      default: begin
        fsm_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r    <= S_IDLE;
      run_r    <= ST_IDLE;
      budget_r <= FULL_BUDGET_RST;
      used_r   <= '0;
      stamp_r  <= '0;
      phase_r  <= '0;
      head_r   <= '0;
      tail_r   <= '0;
      fill_r   <= '0;
      merge_r  <= '0;
    end else begin
      fsm_r    <= fsm_nxt;
      run_r    <= run_nxt;
      budget_r <= budget_nxt;
      used_r   <= used_nxt;
      stamp_r  <= stamp_nxt;
      phase_r  <= phase_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      fill_r   <= fill_nxt;
      merge_r  <= merge_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    now_r   <= now_nxt;
    amt_r   <= amt_nxt;
    rtime_r <= rtime_nxt;
    may_r   <= may_nxt;
    exh_r   <= exh_nxt;
    resv_r  <= resv_nxt;
  end

  assign in_ready  = (fsm_r == S_IDLE);
  assign res_valid = (fsm_r == S_DONE);
  assign res = '{may_run:         may_r,
                 server_state:    run_r,
                 budget_left:     budget_r,
                 pending_count:   4'(fill_r),
                 merged_count:    merge_r,
                 exhausted_event: exh_r,
                 resumed_event:   resv_r};

endmodule
`default_nettype wire
